// ----- sv/sfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg
// Types and constants shared by the sprite framebuffer engine.
// ----------------------------------------------------------------------------
package sfe_pkg;
   localparam int ScreenWidth  = 128;
   localparam int ScreenHeight = 64;
   localparam int LineWords    = (ScreenWidth + 63) / 64;
   localparam int WordBits     = $clog2(LineWords) > 0 ? $clog2(LineWords) : 1;
   localparam int LineBits     = $clog2(ScreenHeight);
   localparam int Depth        = ScreenHeight * LineWords;
   localparam int AddrBits     = $clog2(Depth);

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_SCR_DN = 3'd1,
      CMD_SCR_LT = 3'd2,
      CMD_SCR_RT = 3'd3,
      CMD_DRAW   = 3'd4,
      CMD_MODE   = 3'd5,
      CMD_READ   = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  x_pos;
      logic [7:0]  y_pos;
      logic [6:0]  line_count;
      logic [3:0]  row_index;
      logic [15:0] row_bits;
      logic        mode_value;
   } req_type;

   typedef struct packed {
      logic        collision;
      logic        rejected;
      logic [63:0] pixel_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_WAIT,
      ST_WR,
      ST_DONE
   } state_type;
endpackage

// ----- sv/sfe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfe_ram #(
   parameter int Width = 64,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- sv/sprite_framebuffer_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_framebuffer_engine_top
// One-bit framebuffer with clear, scroll, sprite row XOR and word read.
// ----------------------------------------------------------------------------
// Usage: drive req with start while busy is low; the command is taken at that
// edge. One result per command appears on rsp for one cycle with rsp_valid.
// The frame lives in one RAM of 64-bit words, one address per line word.
// Every walked RAM word goes through a read, wait, write sequence; the
// sequencer touches one word per pass.
// busy drops in the result cycle, so the next command can be taken there.
// Draw and read walk LineWords words; set mode, unused codes, rejected draws
// and scroll downs that do nothing walk no word. Clear and scrolls walk all
// ScreenHeight*LineWords words (128 here). Scroll down walks bottom up, so
// source lines above are still unmodified when read.
// After reset a clearing pass writes zero to every word with busy held high.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module sprite_framebuffer_engine_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  sfe_pkg::req_type req_data,
   output logic            rsp_valid,
   output sfe_pkg::rsp_type rsp_data
);
   localparam int AB = sfe_pkg::AddrBits;
   localparam int LB = sfe_pkg::LineBits;
   localparam int WB = sfe_pkg::WordBits;
   localparam int SW = sfe_pkg::ScreenWidth;
   localparam int SH = sfe_pkg::ScreenHeight;
   localparam int LW = sfe_pkg::LineWords;

   sfe_pkg::state_type state_ff, state_in;
   sfe_pkg::req_type   req_ff, req_in;
   sfe_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AB:0]        idx_ff, idx_in;
   logic               init_ff, init_in;
   logic               ext_ff, ext_in;
   logic               coll_ff, coll_in;
   logic [63:0]        left_ff, left_in;   // carry word for horizontal scroll

   logic          wr_en;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   sfe_ram #(.Width(64), .Depth(sfe_pkg::Depth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // draw geometry
   logic [8:0]  aw, ah;
   logic        wide, bad;
   logic [4:0]  hgt;
   logic [8:0]  x, y, line;
   logic [15:0] bits;
   logic [9:0]  col_lo;

   always_comb begin
      aw   = ext_ff ? 9'(SW) : 9'(SW / 2);
      ah   = ext_ff ? 9'(SH) : 9'(SH / 2);
      wide = ext_ff && (req_ff.line_count == 7'd0);
      hgt  = wide ? 5'd16 : req_ff.line_count[4:0];
      bad  = !wide && (req_ff.line_count == 7'd0 || req_ff.line_count > 7'd16);
      // modulo by two possible power-of-two sizes
      x    = ext_ff ? 9'(req_ff.x_pos & 8'(SW - 1)) : 9'(req_ff.x_pos & 8'(SW / 2 - 1));
      y    = ext_ff ? 9'(req_ff.y_pos & 8'(SH - 1)) : 9'(req_ff.y_pos & 8'(SH / 2 - 1));
      line = y + 9'(req_ff.row_index);
      bits = wide ? req_ff.row_bits : {req_ff.row_bits[7:0], 8'h00};
   end

   // address walk: idx counts words; line and word split of idx
   logic [AB-1:0] cur;
   logic [LB-1:0] cur_line;
   logic [WB-1:0] cur_word;
   logic [AB:0]   last;
   logic [AB-1:0] src;
   logic          src_ok;

   always_comb begin
      cur      = idx_ff[AB-1:0];
      cur_line = LB'(cur / LW);
      cur_word = WB'(cur % LW);
      src      = '0;
      src_ok   = 1'b0;
      unique case (sfe_pkg::cmd_type'(req_ff.command))
         sfe_pkg::CMD_CLEAR, sfe_pkg::CMD_SCR_LT, sfe_pkg::CMD_SCR_RT,
         sfe_pkg::CMD_SCR_DN: last = (AB + 1)'(sfe_pkg::Depth - 1);
         sfe_pkg::CMD_DRAW, sfe_pkg::CMD_READ: last = (AB + 1)'(LW - 1);
         default: last = '0;
      endcase
      if (req_ff.command == sfe_pkg::CMD_SCR_DN) begin
         // walk bottom up: cur = Depth-1-idx
         cur      = AB'(sfe_pkg::Depth - 1) - idx_ff[AB-1:0];
         cur_line = LB'(cur / LW);
         cur_word = WB'(cur % LW);
         src_ok   = {1'b0, cur_line} >= req_ff.line_count[LB:0];
         src      = cur - AB'(32'(req_ff.line_count) * LW);
      end else if (req_ff.command == sfe_pkg::CMD_SCR_RT) begin
         src_ok = 1'b1;
         src    = cur;
      end else if (req_ff.command == sfe_pkg::CMD_SCR_LT) begin
         // walk right to left within each line so the right neighbor is read first
         cur      = AB'(cur_line) * AB'(LW) + AB'(LW - 1 - cur_word);
         cur_word = WB'(LW - 1) - cur_word;
         src_ok   = 1'b1;
         src      = cur;
      end else if (req_ff.command == sfe_pkg::CMD_DRAW) begin
         cur    = AB'(line[LB-1:0]) * AB'(LW) + AB'(idx_ff[WB-1:0]);
         cur_word = idx_ff[WB-1:0];
         src    = cur;
         src_ok = 1'b1;
      end else if (req_ff.command == sfe_pkg::CMD_READ) begin
         src    = AB'(req_ff.y_pos[LB-1:0]) * AB'(LW) + AB'(req_ff.x_pos[7:6]);
         src_ok = 1'b1;
      end
   end

   // sprite mask for the current word
   logic [63:0] mask;
   logic        draw_ok;
   always_comb begin
      mask    = '0;
      draw_ok = !bad && ({5'd0, req_ff.row_index} < 9'(hgt)) && (line < ah);
      for (int j = 0; j < 16; j++) begin
         col_lo = 10'(x) + 10'(j);
         if (bits[15 - j] && (j < 8 || wide) && col_lo < 10'(aw) &&
             col_lo[9:6] == 4'(cur_word)) begin
            mask[63 - col_lo[5:0]] = 1'b1;
         end
      end
      if (!draw_ok) mask = '0;
   end

   logic        do_scroll_dn_clear;
   always_comb begin
      do_scroll_dn_clear = req_ff.line_count == 7'(SH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfe_pkg::ST_WR;
         idx_ff       <= '0;
         init_ff      <= 1'b1;
         ext_ff       <= 1'b0;
         coll_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         ext_ff       <= ext_in;
         coll_ff      <= coll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      left_ff <= left_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      init_in      = init_ff;
      ext_in       = ext_ff;
      coll_in      = coll_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      left_in      = left_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur;
      wr_data      = '0;
      rd_addr      = src;
      busy         = (state_ff != sfe_pkg::ST_IDLE);
      unique case (state_ff)
         sfe_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               idx_in   = '0;
               rsp_in   = '0;
               left_in  = '0;
               state_in = sfe_pkg::ST_RD;
            end
         end
         sfe_pkg::ST_RD: begin
            if (req_ff.command == sfe_pkg::CMD_MODE) begin
               ext_in   = req_ff.mode_value;
               state_in = sfe_pkg::ST_DONE;
            end else if (req_ff.command == sfe_pkg::CMD_NOP) begin
               state_in = sfe_pkg::ST_DONE;
            end else if (req_ff.command == sfe_pkg::CMD_SCR_DN &&
                         (req_ff.line_count == 7'd0 || req_ff.line_count > 7'(SH))) begin
               state_in = sfe_pkg::ST_DONE;
            end else if (req_ff.command == sfe_pkg::CMD_DRAW && bad) begin
               rsp_in.rejected = 1'b1;
               state_in = sfe_pkg::ST_DONE;
            end else begin
               if (req_ff.command == sfe_pkg::CMD_DRAW && req_ff.row_index == 4'd0 &&
                   idx_ff == '0) begin
                  coll_in = 1'b0;
               end
               state_in = sfe_pkg::ST_WAIT;
            end
         end
         sfe_pkg::ST_WAIT: state_in = sfe_pkg::ST_WR;
         sfe_pkg::ST_WR: begin
            if (init_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AB-1:0];
               if (idx_ff == (AB + 1)'(sfe_pkg::Depth - 1)) begin
                  init_in  = 1'b0;
                  idx_in   = '0;
                  state_in = sfe_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               wr_en = 1'b1;
               unique case (sfe_pkg::cmd_type'(req_ff.command))
                  sfe_pkg::CMD_CLEAR: wr_data = '0;
                  sfe_pkg::CMD_SCR_DN:
                     wr_data = (src_ok && !do_scroll_dn_clear) ? rd_data : '0;
                  sfe_pkg::CMD_SCR_RT: begin
                     wr_data = {(cur_word == '0) ? 4'd0 : left_ff[3:0], rd_data[63:4]};
                     left_in = rd_data;
                  end
                  sfe_pkg::CMD_SCR_LT: begin
                     wr_data = {rd_data[59:0],
                                (cur_word == WB'(LW - 1)) ? 4'd0 : left_ff[63:60]};
                     left_in = rd_data;
                  end
                  sfe_pkg::CMD_DRAW: begin
                     wr_data = rd_data ^ mask;
                     if ((rd_data & mask) != '0) coll_in = 1'b1;
                  end
                  default: begin
                     wr_en = 1'b0;
                     rsp_in.pixel_word = rd_data;
                  end
               endcase
               if (idx_ff == last) begin
                  state_in = sfe_pkg::ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = sfe_pkg::ST_RD;
               end
            end
         end
         sfe_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (req_ff.command == sfe_pkg::CMD_DRAW && !rsp_ff.rejected) begin
               rsp_in.collision = coll_ff;
            end
            if (req_ff.command == sfe_pkg::CMD_READ && req_ff.x_pos[7:6] >= 2'(LW)) begin
               rsp_in.pixel_word = '0;
            end
            state_in = sfe_pkg::ST_IDLE;
         end
         default: state_in = sfe_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !rsp_valid_ff) else $error("result during clearing pass");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result held");
endmodule
